/* src/tss_pkg.sv */
// shared types, constants and helpers for the triangle scanline span block
package tss_pkg;

    localparam int COORD_INT_BITS_DEF  = 12;
    localparam int COORD_FRAC_BITS_DEF = 4;

    localparam int ROW_W      = 12;
    localparam int OUT_W      = 12;
    localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_W - 1));
    localparam int OUT_TD_W   = ((3 * OUT_W + 7) / 8) * 8;
    localparam int OUT_TU_W   = 1;
    localparam int SAT_IN_W   = 32;

    typedef struct packed {
        logic signed [ROW_W-1:0] row;
        logic                    in_tri;
    } t_row_info;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(OUT_MAX);
        lo = SAT_IN_W'(OUT_MIN);
        if (v > hi) begin
            return hi[OUT_W-1:0];
        end else if (v < lo) begin
            return lo[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

/* src/tss_sort.sv */
// two-stage vertex sort by y with three strict-less compare-swaps
module tss_sort import tss_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [CW-1:0]    i_vx [3],
    input  logic signed [CW-1:0]    i_vy [3],
    input  logic signed [ROW_W-1:0] i_row,
    output logic                    o_vld,
    output logic signed [CW-1:0]    o_vx [3],
    output logic signed [CW-1:0]    o_vy [3],
    output logic signed [ROW_W-1:0] o_row
);

    logic                    r_a_vld;
    logic signed [CW-1:0]    r_ax [3];
    logic signed [CW-1:0]    r_ay [3];
    logic signed [ROW_W-1:0] r_a_row;
    logic signed [CW-1:0]    n_ax [3];
    logic signed [CW-1:0]    n_ay [3];

    logic                    r_b_vld;
    logic signed [CW-1:0]    r_bx [3];
    logic signed [CW-1:0]    r_by [3];
    logic signed [ROW_W-1:0] r_b_row;
    logic signed [CW-1:0]    n_bx [3];
    logic signed [CW-1:0]    n_by [3];

    // swaps of first with second, then first with third
    always_comb begin
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        n_ax = i_vx;
        n_ay = i_vy;
        tx   = '0;
        ty   = '0;
        if (n_ay[1] < n_ay[0]) begin
            tx      = n_ax[0];
            ty      = n_ay[0];
            n_ax[0] = n_ax[1];
            n_ay[0] = n_ay[1];
            n_ax[1] = tx;
            n_ay[1] = ty;
        end
        if (n_ay[2] < n_ay[0]) begin
            tx      = n_ax[0];
            ty      = n_ay[0];
            n_ax[0] = n_ax[2];
            n_ay[0] = n_ay[2];
            n_ax[2] = tx;
            n_ay[2] = ty;
        end
    end

    // swap of second with third
    always_comb begin
        n_bx = r_ax;
        n_by = r_ay;
        if (r_ay[2] < r_ay[1]) begin
            n_bx[1] = r_ax[2];
            n_by[1] = r_ay[2];
            n_bx[2] = r_ax[1];
            n_by[2] = r_ay[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_a_row <= i_row;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_b_row <= r_a_row;
        end
    end

    assign o_vld = r_b_vld;
    assign o_vx  = r_bx;
    assign o_vy  = r_by;
    assign o_row = r_b_row;

endmodule

/* src/tss_edge.sv */
// row range test, edge selection and numerator product for both edges
module tss_edge import tss_pkg::*; #(
    parameter int CW   = 16,
    parameter int FRAC = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [CW-1:0]    i_vx [3],
    input  logic signed [CW-1:0]    i_vy [3],
    input  logic signed [ROW_W-1:0] i_row,
    output logic                    o_vld,
    output t_row_info               o_info,
    output logic signed [CW-1:0]    o_ax [2],
    output logic                    o_neg [2],
    output logic [CW-1:0]           o_dy [2],
    output logic [2*CW-1:0]         o_m [2]
);

    localparam int YW = ((CW > ROW_W + FRAC) ? CW : ROW_W + FRAC) + 1;

    t_row_info            n_info;
    logic signed [CW-1:0] n_ax  [2];
    logic                 n_neg [2];
    logic [CW-1:0]        n_mag [2];
    logic [CW-1:0]        n_dy  [2];
    logic [CW-1:0]        n_t   [2];

    logic                 r_a_vld;
    t_row_info            r_a_info;
    logic signed [CW-1:0] r_a_ax  [2];
    logic                 r_a_neg [2];
    logic [CW-1:0]        r_a_mag [2];
    logic [CW-1:0]        r_a_dy  [2];
    logic [CW-1:0]        r_a_t   [2];

    logic                 r_b_vld;
    t_row_info            r_b_info;
    logic signed [CW-1:0] r_b_ax  [2];
    logic                 r_b_neg [2];
    logic [CW-1:0]        r_b_dy  [2];
    logic [2*CW-1:0]      r_b_m   [2];

    always_comb begin
        logic signed [YW-1:0] yy;
        logic signed [YW-1:0] tw;
        logic signed [CW:0]   dx;
        logic signed [CW:0]   dyw;
        logic signed [CW:0]   adx;
        logic                 second;
        logic                 degen;
        logic [1:0]           ia;
        logic [1:0]           ib;
        yy          = YW'(i_row);
        yy          = yy <<< FRAC;
        n_info.row  = i_row;
        n_info.in_tri = (yy >= YW'(i_vy[0])) && (yy <= YW'(i_vy[2]));
        second      = (yy > YW'(i_vy[1])) || (i_vy[1] == i_vy[0]);
        for (int l = 0; l < 2; l++) begin
            if (l == 0) begin
                ia = 2'd0;
                ib = 2'd2;
            end else if (second) begin
                ia = 2'd1;
                ib = 2'd2;
            end else begin
                ia = 2'd0;
                ib = 2'd1;
            end
            dx    = (CW+1)'(i_vx[ib]) - (CW+1)'(i_vx[ia]);
            dyw   = (CW+1)'(i_vy[ib]) - (CW+1)'(i_vy[ia]);
            tw    = yy - YW'(i_vy[ia]);
            degen = (dyw == '0);
            adx   = dx[CW] ? -dx : dx;
            n_ax[l]  = i_vx[ia];
            n_neg[l] = !degen && dx[CW];
            n_mag[l] = degen ? '0 : adx[CW-1:0];
            n_dy[l]  = degen ? CW'(1) : dyw[CW-1:0];
            n_t[l]   = degen ? '0 : tw[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_info <= n_info;
            r_a_ax   <= n_ax;
            r_a_neg  <= n_neg;
            r_a_mag  <= n_mag;
            r_a_dy   <= n_dy;
            r_a_t    <= n_t;
            r_b_info <= r_a_info;
            r_b_ax   <= r_a_ax;
            r_b_neg  <= r_a_neg;
            r_b_dy   <= r_a_dy;
            for (int l = 0; l < 2; l++) begin
                r_b_m[l] <= r_a_mag[l] * r_a_t[l];
            end
        end
    end

    assign o_vld  = r_b_vld;
    assign o_info = r_b_info;
    assign o_ax   = r_b_ax;
    assign o_neg  = r_b_neg;
    assign o_dy   = r_b_dy;
    assign o_m    = r_b_m;

endmodule

/* src/tss_div.sv */
// two-lane pipelined restoring divider, one quotient bit per stage
module tss_div import tss_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  t_row_info            i_info,
    input  logic signed [CW-1:0] i_ax [2],
    input  logic                 i_neg [2],
    input  logic [CW-1:0]        i_dy [2],
    input  logic [2*CW-1:0]      i_m [2],
    output logic                 o_vld,
    output t_row_info            o_info,
    output logic signed [CW-1:0] o_ax [2],
    output logic                 o_neg [2],
    output logic [CW-1:0]        o_q [2],
    output logic                 o_rnz [2]
);

    logic                 r_vld  [CW];
    t_row_info            r_info [CW];
    logic signed [CW-1:0] r_ax   [CW][2];
    logic                 r_neg  [CW][2];
    logic [CW-1:0]        r_dy   [CW][2];
    logic [CW-1:0]        r_rem  [CW][2];
    logic [CW-1:0]        r_lo   [CW][2];

    for (genvar s = 0; s < CW; s++) begin : g_stage
        logic                 w_vld_in;
        t_row_info            w_info_in;
        logic signed [CW-1:0] w_ax_in  [2];
        logic                 w_neg_in [2];
        logic [CW-1:0]        w_dy_in  [2];
        logic [CW-1:0]        w_rem_in [2];
        logic [CW-1:0]        w_lo_in  [2];
        logic [CW-1:0]        n_rem    [2];
        logic [CW-1:0]        n_lo     [2];

        if (s == 0) begin : g_src_first
            always_comb begin
                w_vld_in  = i_vld;
                w_info_in = i_info;
                w_ax_in   = i_ax;
                w_neg_in  = i_neg;
                w_dy_in   = i_dy;
                for (int l = 0; l < 2; l++) begin
                    w_rem_in[l] = i_m[l][2*CW-1:CW];
                    w_lo_in[l]  = i_m[l][CW-1:0];
                end
            end
        end else begin : g_src_prev
            always_comb begin
                w_vld_in  = r_vld[s-1];
                w_info_in = r_info[s-1];
                w_ax_in   = r_ax[s-1];
                w_neg_in  = r_neg[s-1];
                w_dy_in   = r_dy[s-1];
                w_rem_in  = r_rem[s-1];
                w_lo_in   = r_lo[s-1];
            end
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            logic [CW:0] sh;
            logic [CW:0] df;
            logic        ge;
            for (int l = 0; l < 2; l++) begin
                sh       = {w_rem_in[l], w_lo_in[l][CW-1]};
                df       = sh - {1'b0, w_dy_in[l]};
                ge       = (sh >= {1'b0, w_dy_in[l]});
                n_rem[l] = ge ? df[CW-1:0] : sh[CW-1:0];
                n_lo[l]  = {w_lo_in[l][CW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_info[s] <= w_info_in;
                r_ax[s]   <= w_ax_in;
                r_neg[s]  <= w_neg_in;
                r_dy[s]   <= w_dy_in;
                r_rem[s]  <= n_rem;
                r_lo[s]   <= n_lo;
            end
        end
    end

    assign o_vld  = r_vld[CW-1];
    assign o_info = r_info[CW-1];
    assign o_ax   = r_ax[CW-1];
    assign o_neg  = r_neg[CW-1];
    assign o_q    = r_lo[CW-1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            o_rnz[l] = |r_rem[CW-1][l];
        end
    end

endmodule

/* src/tss_round.sv */
// edge x floor and ceiling, pixel rounding, saturation and span ordering
module tss_round import tss_pkg::*; #(
    parameter int CW   = 16,
    parameter int FRAC = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  t_row_info               i_info,
    input  logic signed [CW-1:0]    i_ax [2],
    input  logic                    i_neg [2],
    input  logic [CW-1:0]           i_q [2],
    input  logic                    i_rnz [2],
    output logic                    o_vld,
    output logic                    o_inside,
    output logic signed [ROW_W-1:0] o_row,
    output logic signed [OUT_W-1:0] o_start,
    output logic signed [OUT_W-1:0] o_end
);

    localparam logic signed [CW+2:0] CEIL_ADD = (CW+3)'((1 << FRAC) - 1);

    logic                    r_a_vld;
    t_row_info               r_a_info;
    logic signed [CW+1:0]    r_a_fl [2];
    logic signed [CW+1:0]    r_a_ce [2];
    logic signed [CW+1:0]    n_fl   [2];
    logic signed [CW+1:0]    n_ce   [2];

    logic                    r_out_vld;
    logic                    r_out_inside;
    logic signed [ROW_W-1:0] r_out_row;
    logic signed [OUT_W-1:0] r_out_start;
    logic signed [OUT_W-1:0] r_out_end;
    logic signed [OUT_W-1:0] n_start;
    logic signed [OUT_W-1:0] n_end;

    // exact floor and ceiling of the edge x in coordinate units
    always_comb begin
        logic signed [CW+1:0] q;
        logic signed [CW+1:0] a;
        logic signed [CW+1:0] rz;
        for (int l = 0; l < 2; l++) begin
            q  = $signed({2'b00, i_q[l]});
            a  = (CW+2)'(i_ax[l]);
            rz = $signed({{(CW+1){1'b0}}, i_rnz[l]});
            n_fl[l] = i_neg[l] ? a - q - rz : a + q;
            n_ce[l] = i_neg[l] ? a - q : a + q + rz;
        end
    end

    always_comb begin
        logic signed [CW+2:0]    fl;
        logic signed [CW+2:0]    ce;
        logic signed [OUT_W-1:0] fs [2];
        logic signed [OUT_W-1:0] cs [2];
        for (int l = 0; l < 2; l++) begin
            fl    = (CW+3)'(r_a_fl[l]) >>> FRAC;
            ce    = ((CW+3)'(r_a_ce[l]) + CEIL_ADD) >>> FRAC;
            fs[l] = sat_out(SAT_IN_W'(fl));
            cs[l] = sat_out(SAT_IN_W'(ce));
        end
        if (r_a_info.in_tri) begin
            n_start = (cs[0] < cs[1]) ? cs[0] : cs[1];
            n_end   = (fs[0] > fs[1]) ? fs[0] : fs[1];
        end else begin
            n_start = '0;
            n_end   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld   <= i_vld;
            r_out_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_info     <= i_info;
            r_a_fl       <= n_fl;
            r_a_ce       <= n_ce;
            r_out_inside <= r_a_info.in_tri;
            r_out_row    <= r_a_info.row;
            r_out_start  <= n_start;
            r_out_end    <= n_end;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_inside = r_out_inside;
    assign o_row    = r_out_row;
    assign o_start  = r_out_start;
    assign o_end    = r_out_end;

endmodule

/* src/triangle_scanline_span.sv */
// throughput: one beat per cycle without output stalls, set by the one-bit-per-stage divider lanes of both edges
// a stalled output freezes every stage; one input beat in flight is caught by the skid register
// reset: synchronous, active low, clears all valid bits; no memories and no clearing pass
module triangle_scanline_span import tss_pkg::*; #(
    parameter int  COORD_INT_BITS  = COORD_INT_BITS_DEF,
    parameter int  COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    localparam int CW              = COORD_INT_BITS + COORD_FRAC_BITS,
    localparam int IN_DW           = 6 * CW + ROW_W,
    localparam int IN_TW           = ((IN_DW + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, row_y, zero fill
    input  logic [IN_TW-1:0]    s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // span_row, span_start, span_end, zero fill
    output logic [OUT_TD_W-1:0] m_axis_tdata,
    // span_valid
    output logic [OUT_TU_W-1:0] m_axis_tuser
);

    logic                    w_en;
    logic                    w_accept;

    logic                    r_skid_vld;
    logic [IN_DW-1:0]        r_skid_data;
    logic                    r_s1_vld;
    logic [IN_DW-1:0]        r_s1_data;

    logic signed [CW-1:0]    w_in_vx [3];
    logic signed [CW-1:0]    w_in_vy [3];
    logic signed [ROW_W-1:0] w_in_row;

    logic                    w_so_vld;
    logic signed [CW-1:0]    w_so_vx [3];
    logic signed [CW-1:0]    w_so_vy [3];
    logic signed [ROW_W-1:0] w_so_row;

    logic                    w_eg_vld;
    t_row_info               w_eg_info;
    logic signed [CW-1:0]    w_eg_ax  [2];
    logic                    w_eg_neg [2];
    logic [CW-1:0]           w_eg_dy  [2];
    logic [2*CW-1:0]         w_eg_m   [2];

    logic                    w_dv_vld;
    t_row_info               w_dv_info;
    logic signed [CW-1:0]    w_dv_ax  [2];
    logic                    w_dv_neg [2];
    logic [CW-1:0]           w_dv_q   [2];
    logic                    w_dv_rnz [2];

    logic                    w_out_vld;
    logic                    w_out_inside;
    logic signed [ROW_W-1:0] w_out_row;
    logic signed [OUT_W-1:0] w_out_start;
    logic signed [OUT_W-1:0] w_out_end;

    assign w_en          = !w_out_vld || m_axis_tready;
    assign s_axis_tready = !r_skid_vld;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_s1_vld   <= 1'b0;
        end else if (w_en) begin
            r_skid_vld <= 1'b0;
            r_s1_vld   <= r_skid_vld || w_accept;
        end else if (w_accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_data <= r_skid_vld ? r_skid_data : s_axis_tdata[IN_DW-1:0];
        end
        if (!w_en && w_accept) begin
            r_skid_data <= s_axis_tdata[IN_DW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_in_vx[k] = r_s1_data[2*k*CW +: CW];
            w_in_vy[k] = r_s1_data[(2*k+1)*CW +: CW];
        end
        w_in_row = r_s1_data[6*CW +: ROW_W];
    end

    tss_sort #(
        .CW (CW)
    ) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s1_vld),
        .i_vx    (w_in_vx),
        .i_vy    (w_in_vy),
        .i_row   (w_in_row),
        .o_vld   (w_so_vld),
        .o_vx    (w_so_vx),
        .o_vy    (w_so_vy),
        .o_row   (w_so_row)
    );

    tss_edge #(
        .CW   (CW),
        .FRAC (COORD_FRAC_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_so_vld),
        .i_vx    (w_so_vx),
        .i_vy    (w_so_vy),
        .i_row   (w_so_row),
        .o_vld   (w_eg_vld),
        .o_info  (w_eg_info),
        .o_ax    (w_eg_ax),
        .o_neg   (w_eg_neg),
        .o_dy    (w_eg_dy),
        .o_m     (w_eg_m)
    );

    tss_div #(
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_eg_vld),
        .i_info  (w_eg_info),
        .i_ax    (w_eg_ax),
        .i_neg   (w_eg_neg),
        .i_dy    (w_eg_dy),
        .i_m     (w_eg_m),
        .o_vld   (w_dv_vld),
        .o_info  (w_dv_info),
        .o_ax    (w_dv_ax),
        .o_neg   (w_dv_neg),
        .o_q     (w_dv_q),
        .o_rnz   (w_dv_rnz)
    );

    tss_round #(
        .CW   (CW),
        .FRAC (COORD_FRAC_BITS)
    ) u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_dv_vld),
        .i_info   (w_dv_info),
        .i_ax     (w_dv_ax),
        .i_neg    (w_dv_neg),
        .i_q      (w_dv_q),
        .i_rnz    (w_dv_rnz),
        .o_vld    (w_out_vld),
        .o_inside (w_out_inside),
        .o_row    (w_out_row),
        .o_start  (w_out_start),
        .o_end    (w_out_end)
    );

    assign m_axis_tvalid = w_out_vld;
    assign m_axis_tdata  = OUT_TD_W'({w_out_end, w_out_start, w_out_row});
    assign m_axis_tuser  = OUT_TU_W'(w_out_inside);

endmodule

/* src/tss_checker.sv */
// port-level checks for the triangle scanline span block, bound to the top level
module tss_checker import tss_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_TD_W-1:0] m_axis_tdata,
    input logic [OUT_TU_W-1:0] m_axis_tuser
);

    // a stalled output beat is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // rows outside the triangle report an empty span of zeros
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[3*OUT_W-1:OUT_W] == '0)
        else $error("span not zero for row outside triangle");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // input side only backs off when the output side was stalled
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without output stall");

    // skid register drains as soon as the output moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && (!m_axis_tvalid || m_axis_tready) |=> s_axis_tready)
        else $error("skid beat not drained");

endmodule

bind triangle_scanline_span tss_checker u_tss_checker (.*);

/* test/tb_triangle_scanline_span.sv */
// testbench for triangle_scanline_span: directed and random triangle row queries against a span predictor
`timescale 1ns / 100ps

import tss_pkg::*;

typedef struct packed {
    logic [3:0]              pad;
    logic signed [ROW_W-1:0] row;
    logic signed [15:0]      v3_y;
    logic signed [15:0]      v3_x;
    logic signed [15:0]      v2_y;
    logic signed [15:0]      v2_x;
    logic signed [15:0]      v1_y;
    logic signed [15:0]      v1_x;
} t_query;

typedef struct packed {
    logic                    covered;
    logic signed [OUT_W-1:0] row;
    logic signed [OUT_W-1:0] x_lo;
    logic signed [OUT_W-1:0] x_hi;
} t_span;

typedef struct {
    longint x;
    longint y;
} t_vertex;

class span_scoreboard;
    t_span  spans_due[$];
    int     errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return spans_due.size();
    endfunction

    function longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function longint ceil_quot(longint n, longint d);
        return -floor_quot(-n, d);
    endfunction

    function longint clamp_out(longint v);
        if (v > OUT_MAX) begin
            return OUT_MAX;
        end
        if (v < OUT_MIN) begin
            return OUT_MIN;
        end
        return v;
    endfunction

    // x of edge a-b at height yy as num / den, den > 0
    function void cut_edge(t_vertex a, t_vertex b, longint yy, output longint num,
                           output longint den);
        longint dy;
        if (a.y == b.y) begin
            num = a.x;
            den = 1;
            return;
        end
        dy  = b.y - a.y;
        num = a.x * dy + (b.x - a.x) * (yy - a.y);
        if (dy < 0) begin
            dy  = -dy;
            num = -num;
        end
        den = dy;
    endfunction

    function t_span predict_span(t_query q);
        t_span   r;
        t_vertex v[3];
        t_vertex t;
        longint  scale, yy, na, da, nb, db, ca, cb, fa, fb, s, e;
        logic    lower_half;
        scale = longint'(1) << COORD_FRAC_BITS_DEF;
        v[0].x = q.v1_x; v[0].y = q.v1_y;
        v[1].x = q.v2_x; v[1].y = q.v2_y;
        v[2].x = q.v3_x; v[2].y = q.v3_y;
        yy = longint'(q.row) * scale;
        if (v[1].y < v[0].y) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        if (v[2].y < v[0].y) begin t = v[0]; v[0] = v[2]; v[2] = t; end
        if (v[2].y < v[1].y) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        r.row     = q.row;
        r.covered = (yy >= v[0].y) && (yy <= v[2].y);
        r.x_lo    = '0;
        r.x_hi    = '0;
        if (!r.covered) begin
            return r;
        end
        lower_half = (yy > v[1].y) || (v[1].y == v[0].y);
        cut_edge(v[0], v[2], yy, na, da);
        if (lower_half) begin
            cut_edge(v[1], v[2], yy, nb, db);
        end else begin
            cut_edge(v[0], v[1], yy, nb, db);
        end
        ca = ceil_quot(na, da * scale);
        cb = ceil_quot(nb, db * scale);
        fa = floor_quot(na, da * scale);
        fb = floor_quot(nb, db * scale);
        s = clamp_out(ca < cb ? ca : cb);
        e = clamp_out(fa > fb ? fa : fb);
        r.x_lo = s[OUT_W-1:0];
        r.x_hi = e[OUT_W-1:0];
        return r;
    endfunction

    function void note_query(t_query q);
        spans_due.push_back(predict_span(q));
    endfunction

    function void check_span(t_span got);
        t_span exp_span;
        if (spans_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected span beat: covered=%0d row=%0d start=%0d end=%0d",
                         got.covered, got.row, got.x_lo, got.x_hi);
            end
            return;
        end
        exp_span = spans_due.pop_front();
        if (got.covered !== exp_span.covered || got.row !== exp_span.row ||
            got.x_lo !== exp_span.x_lo || got.x_hi !== exp_span.x_hi) begin
            errors++;
            if (errors <= 10) begin
                $display("span mismatch: expected covered=%0d row=%0d start=%0d end=%0d",
                         exp_span.covered, exp_span.row, exp_span.x_lo, exp_span.x_hi);
                $display("               got      covered=%0d row=%0d start=%0d end=%0d",
                         got.covered, got.row, got.x_lo, got.x_hi);
            end
        end
    endfunction
endclass

module tb_triangle_scanline_span;

    localparam int IN_TW          = 112;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1750;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_TW-1:0]    s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0] m_axis_tdata;
    logic [OUT_TU_W-1:0] m_axis_tuser;

    span_scoreboard book = new();
    int             idle_cycles = 0;
    int             burst_left  = 0;
    int             ready_left  = 0;

    triangle_scanline_span u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_span got;
        logic  moved;
        moved = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            book.note_query(t_query'(s_axis_tdata));
            moved = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.covered = m_axis_tuser[0];
            got.row     = m_axis_tdata[OUT_W-1:0];
            got.x_lo    = m_axis_tdata[2*OUT_W-1:OUT_W];
            got.x_hi    = m_axis_tdata[3*OUT_W-1:2*OUT_W];
            book.check_span(got);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        int r;
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            r = $urandom_range(99);
            if (r < 50) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(8);
            end else if (r < 85) begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(2);
            end else if (r < 95) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(80, 20);
            end else begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(60, 20);
            end
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(39) == 0) begin
            burst_left = $urandom_range(80, 30);
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    task send_query(input t_query q);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= q;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task send_tri(input int x1, input int y1, input int x2, input int y2, input int x3,
                  input int y3, input int r);
        t_query q;
        q.pad  = '0;
        q.v1_x = 16'(x1); q.v1_y = 16'(y1);
        q.v2_x = 16'(x2); q.v2_y = 16'(y2);
        q.v3_x = 16'(x3); q.v3_y = 16'(y3);
        q.row  = ROW_W'(r);
        send_query(q);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(negedge i_clk);
    endtask

    function automatic t_query rand_query();
        t_query q;
        int     mode, w, cx, cy, k, ymin, ymax, lo, hi;
        int     xs[3];
        int     ys[3];
        q.pad = '0;
        mode  = $urandom_range(99);
        if (mode < 15) begin
            q.v1_x = 16'($urandom); q.v1_y = 16'($urandom);
            q.v2_x = 16'($urandom); q.v2_y = 16'($urandom);
            q.v3_x = 16'($urandom); q.v3_y = 16'($urandom);
            q.row  = ROW_W'($urandom);
            return q;
        end
        case ($urandom_range(3))
            0: w = 64;
            1: w = 1024;
            2: w = 16384;
            default: w = 65535;
        endcase
        cx = rand_between(-32768, 32767);
        cy = rand_between(-32768, 32767);
        for (k = 0; k < 3; k++) begin
            xs[k] = clip(cx + rand_between(-w, w), -32768, 32767);
            ys[k] = clip(cy + rand_between(-w, w), -32768, 32767);
        end
        if (mode < 35) begin
            k = $urandom_range(2);
            ys[(k + 1) % 3] = ys[k];
        end
        if (mode >= 35 && mode < 45) begin
            for (k = 0; k < 3; k++) begin
                ys[k] = ys[k] & ~32'sd15;
            end
        end
        ymin = ys[0];
        ymax = ys[0];
        for (k = 1; k < 3; k++) begin
            if (ys[k] < ymin) ymin = ys[k];
            if (ys[k] > ymax) ymax = ys[k];
        end
        lo = clip((ymin >>> 4) - 1, -2048, 2047);
        hi = clip((ymax >>> 4) + 1, -2048, 2047);
        q.v1_x = 16'(xs[0]); q.v1_y = 16'(ys[0]);
        q.v2_x = 16'(xs[1]); q.v2_y = 16'(ys[1]);
        q.v3_x = 16'(xs[2]); q.v3_y = 16'(ys[2]);
        q.row  = ROW_W'(rand_between(lo, hi));
        return q;
    endfunction

    initial begin
        int n;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ordinary triangle: below, top row, upper half, middle vertex row, lower half, last vertex row, above
        send_tri(0, 0, 320, 160, -160, 320, -1);
        send_tri(0, 0, 320, 160, -160, 320, 0);
        send_tri(0, 0, 320, 160, -160, 320, 5);
        send_tri(0, 0, 320, 160, -160, 320, 10);
        send_tri(0, 0, 320, 160, -160, 320, 15);
        send_tri(0, 0, 320, 160, -160, 320, 20);
        send_tri(0, 0, 320, 160, -160, 320, 21);
        // flat top, flat bottom, all on one line
        send_tri(0, 0, 320, 0, 160, 320, 0);
        send_tri(0, 0, 320, 0, 160, 320, 10);
        send_tri(0, 0, -160, 320, 160, 320, 20);
        send_tri(0, 48, 160, 48, -32, 48, 3);
        // fractional top and bottom rows
        send_tri(0, 17, 64, 30, 32, 47, 1);
        send_tri(0, 17, 64, 30, 32, 47, 2);
        send_tri(0, 17, 64, 30, 32, 47, 3);
        // saturation at both ends
        send_tri(32767, 0, 32767, 160, 32767, 320, 5);
        send_tri(-32768, -32768, -32768, 32767, 32767, 0, -2048);
        send_tri(-32768, -32768, -32768, 32767, 32767, 0, 2047);
        send_tri(32767, 32767, 32767, 32767, 32767, 32767, 2047);
        send_tri(-32768, -32768, -32768, -32768, -32768, -32768, -2048);
        // thin sliver gives a reversed span
        send_tri(5, 0, 6, 160, 7, 320, 5);
        // vertices in reverse y order, widest triangle
        send_tri(100, 300, -50, 200, 40, -100, 0);
        send_tri(100, 300, -50, 200, 40, -100, 15);
        send_tri(-32768, -32768, 32767, -32768, 0, 32767, 0);
        drain();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            send_query(rand_query());
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (book.errors == 0 && book.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
